@@ src/dtf_pkg.sv @@
// ============================================================================
// dtf_pkg: shared definitions for the decimal text to fixed point converter
// Holds the default sizes, the character codes, the limits and the table of
// powers of ten that scales the kept fraction digits.
// ============================================================================
package dtf_pkg;

    // Default number of kept fraction digits and binary fraction bits.
    localparam int DTF_FRAC_DIGITS = 9;
    localparam int DTF_FRAC_BITS   = 32;

    // Largest accepted integer magnitude and the length limits.
    localparam logic [31:0] DTF_MAX_MAG       = 32'd2147483647;
    localparam logic [3:0]  DTF_LEN_DIGIT_MAX = 4'd10;
    localparam logic [3:0]  DTF_LEN_MINUS_MAX = 4'd11;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [7:0]         char_t;
    typedef logic signed [63:0] fixed_t;

    // Power of ten for a count of fraction digits; at most nine digits.
    function automatic logic [29:0] pow10(input logic [3:0] n);
        logic [29:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

@@ src/dtf_if.sv @@
// ============================================================================
// dtf_if: valid/ready channels of the decimal text to fixed point converter
// One channel carries a text byte, the other a converted result.
// ============================================================================
interface dtf_char_if;
    import dtf_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface dtf_result_if;
    import dtf_pkg::*;

    logic   valid;
    logic   ready;
    fixed_t value;
    logic   error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

@@ src/dtf_frac_div.sv @@
// ============================================================================
// dtf_frac_div: restoring divider for the binary fraction
// Divides numerator * 2^FRAC_BITS by the divisor, one quotient bit a cycle.
// The numerator must be smaller than the divisor.
// ============================================================================
module dtf_frac_div #(
    parameter int FRAC_BITS = dtf_pkg::DTF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [29:0]          numerator,
    input  logic [29:0]          divisor,
    output logic                 done,
    output logic [FRAC_BITS-1:0] quotient
);
    import dtf_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [29:0]          rem_reg;
    logic [29:0]          div_reg;
    logic [FRAC_BITS-1:0] quo_reg;

    logic [30:0] shifted;
    logic [30:0] diff;
    logic        fits;

    // One trial subtraction of the doubled remainder.
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= CNT_W'(FRAC_BITS);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder and quotient bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numerator;
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[29:0] : shifted[29:0];
            quo_reg <= {quo_reg[FRAC_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/decimal_text_to_fixed.sv @@
// ============================================================================
// decimal_text_to_fixed: ASCII decimal text to signed fixed point
// Parses a zero-terminated decimal string one byte at a time and returns the
// value in Q32.FRAC_BITS with a sticky format and range error flag.
// ============================================================================
//
//  Channel  Side    Payload            Transactions
//  text     sink    character (8 b)    one per string byte, 0 ends the string
//  result   source  value (64 b), error one per terminating zero byte
//
//  An ordinary byte is taken as soon as it is offered. The terminator starts
//  the shared fraction divider, which yields one quotient bit a cycle; the
//  next byte is taken once the divider is done and the result is loaded.
//  The result sits in an output register; a new string is taken while it
//  waits, and only the byte after the next terminator stalls until it is taken.
//  Reset is asynchronous and returns the parser to the start of a string.
//
module decimal_text_to_fixed #(
    parameter int FRAC_DIGITS = dtf_pkg::DTF_FRAC_DIGITS,
    parameter int FRAC_BITS   = dtf_pkg::DTF_FRAC_BITS
) (
    input logic          clk,
    input logic          rst_n,
    dtf_char_if.sink     text,
    dtf_result_if.source result
);
    import dtf_pkg::*;

    typedef enum logic [1:0] {
        S_PARSE,
        S_DIVIDE,
        S_OUTPUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_TRAIL
    } phase_t;

    typedef enum logic [1:0] {
        FC_NONE,
        FC_DIGIT,
        FC_MINUS,
        FC_OTHER
    } first_class_t;

    ctrl_state_t  state_reg, state_next;
    phase_t       phase_reg, phase_next;
    first_class_t first_class_reg, first_class_next;
    logic [3:0]   length_count_reg, length_count_next;
    logic         negative_reg, negative_next;
    logic         fault_reg, fault_next;
    logic [31:0]  integer_acc_reg, integer_acc_next;
    logic [29:0]  fraction_acc_reg, fraction_acc_next;
    logic [3:0]   fraction_count_reg, fraction_count_next;
    logic         error_reg, error_next;

    logic         out_valid_reg;
    fixed_t       out_value_reg;
    logic         out_error_reg;

    logic         accept;
    logic         is_term;
    logic         digit_char;
    logic         blank_char;
    logic [3:0]   digit;
    logic [35:0]  int_prod;
    logic [29:0]  frac_prod;
    logic         term_error;

    logic                 div_done;
    logic [FRAC_BITS-1:0] div_quotient;
    logic [63:0]          magnitude;
    fixed_t               final_value;
    logic                 load_out;

    // Byte classification.
    assign accept     = text.valid && text.ready;
    assign is_term    = (text.character == CH_NUL);
    assign digit_char = text.character inside {[CH_ZERO:CH_NINE]};
    assign blank_char = text.character inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign digit      = 4'(text.character - CH_ZERO);

    // Decimal accumulation steps; the integer one saturates.
    assign int_prod  = (36'(integer_acc_reg) << 3) + (36'(integer_acc_reg) << 1)
                       + 36'(digit);
    assign frac_prod = 30'((fraction_acc_reg << 3) + (fraction_acc_reg << 1))
                       + 30'(digit);

    // Error rules checked when the terminator arrives.
    assign term_error = fault_reg
        || (phase_reg == PH_LEAD) || (phase_reg == PH_SIGN)
        || (first_class_reg == FC_NONE)
        || ((first_class_reg == FC_DIGIT) && (length_count_reg > DTF_LEN_DIGIT_MAX))
        || ((first_class_reg == FC_MINUS) && (length_count_reg > DTF_LEN_MINUS_MAX))
        || (integer_acc_reg > DTF_MAX_MAG)
        || ((integer_acc_reg == DTF_MAX_MAG) && (fraction_acc_reg != '0));

    // Shared divider turns the kept decimal fraction into binary bits.
    dtf_frac_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frac_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && is_term),
        .numerator (fraction_acc_reg),
        .divisor   (pow10(fraction_count_reg)),
        .done      (div_done),
        .quotient  (div_quotient)
    );

    // Magnitude, clamp and sign of the final value.
    assign magnitude = 64'({integer_acc_reg, div_quotient});
    always_comb
    begin
        if (negative_reg)
        begin
            if (magnitude > 64'h8000_0000_0000_0000)
                final_value = fixed_t'(64'h8000_0000_0000_0000);
            else
                final_value = fixed_t'(-magnitude);
        end
        else
        begin
            if (magnitude[63])
                final_value = fixed_t'(64'h7FFF_FFFF_FFFF_FFFF);
            else
                final_value = fixed_t'(magnitude);
        end
    end

    assign load_out = (state_reg == S_OUTPUT) && (!out_valid_reg || result.ready);

    // Parser and sequencer next state.
    always_comb
    begin
        state_next          = state_reg;
        phase_next          = phase_reg;
        first_class_next    = first_class_reg;
        length_count_next   = length_count_reg;
        negative_next       = negative_reg;
        fault_next          = fault_reg;
        integer_acc_next    = integer_acc_reg;
        fraction_acc_next   = fraction_acc_reg;
        fraction_count_next = fraction_count_reg;
        error_next          = error_reg;

        case (state_reg)
            S_PARSE:
            begin
                if (accept && is_term)
                begin
                    error_next = term_error;
                    state_next = S_DIVIDE;
                end
                else if (accept)
                begin
                    if (first_class_reg == FC_NONE)
                    begin
                        if (digit_char)
                            first_class_next = FC_DIGIT;
                        else if (text.character == CH_MINUS)
                            first_class_next = FC_MINUS;
                        else
                            first_class_next = FC_OTHER;
                    end
                    if (length_count_reg != 4'hF)
                        length_count_next = length_count_reg + 4'd1;

                    case (phase_reg)
                        PH_LEAD:
                        begin
                            if (blank_char)
                            begin
                                phase_next = PH_LEAD;
                            end
                            else if (digit_char)
                            begin
                                integer_acc_next = (int_prod[35:32] != 4'd0) ? '1
                                                   : int_prod[31:0];
                                phase_next = PH_INT;
                            end
                            else if (text.character inside {CH_PLUS, CH_MINUS})
                            begin
                                negative_next = (text.character == CH_MINUS);
                                phase_next    = PH_SIGN;
                            end
                            else if (text.character == CH_DOT)
                            begin
                                fault_next = 1'b1;
                                phase_next = PH_FRAC;
                            end
                            else
                            begin
                                fault_next = 1'b1;
                                phase_next = PH_TRAIL;
                            end
                        end
                        PH_SIGN:
                        begin
                            if (digit_char)
                            begin
                                integer_acc_next = (int_prod[35:32] != 4'd0) ? '1
                                                   : int_prod[31:0];
                                phase_next = PH_INT;
                            end
                            else
                            begin
                                fault_next = 1'b1;
                                phase_next = (text.character == CH_DOT) ? PH_FRAC
                                                                        : PH_TRAIL;
                            end
                        end
                        PH_INT:
                        begin
                            if (digit_char)
                            begin
                                integer_acc_next = (int_prod[35:32] != 4'd0) ? '1
                                                   : int_prod[31:0];
                            end
                            else if (text.character == CH_DOT)
                            begin
                                phase_next = PH_FRAC;
                            end
                            else
                            begin
                                fault_next = 1'b1;
                                phase_next = PH_TRAIL;
                            end
                        end
                        PH_FRAC:
                        begin
                            if (digit_char)
                            begin
                                if (fraction_count_reg < 4'(FRAC_DIGITS))
                                begin
                                    fraction_acc_next   = frac_prod;
                                    fraction_count_next = fraction_count_reg + 4'd1;
                                end
                            end
                            else
                            begin
                                fault_next = 1'b1;
                                phase_next = PH_TRAIL;
                            end
                        end
                        default:
                        begin
                            fault_next = 1'b1;
                            phase_next = PH_TRAIL;
                        end
                    endcase
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                    state_next = S_OUTPUT;
            end
            S_OUTPUT:
            begin
                // Hand the result over and start a fresh string.
                if (load_out)
                begin
                    state_next          = S_PARSE;
                    phase_next          = PH_LEAD;
                    first_class_next    = FC_NONE;
                    length_count_next   = '0;
                    negative_next       = 1'b0;
                    fault_next          = 1'b0;
                    integer_acc_next    = '0;
                    fraction_acc_next   = '0;
                    fraction_count_next = '0;
                end
            end
            default:
            begin
                state_next = S_PARSE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_PARSE;
            phase_reg          <= PH_LEAD;
            first_class_reg    <= FC_NONE;
            length_count_reg   <= '0;
            negative_reg       <= 1'b0;
            fault_reg          <= 1'b0;
            integer_acc_reg    <= '0;
            fraction_acc_reg   <= '0;
            fraction_count_reg <= '0;
            error_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_value_reg      <= '0;
            out_error_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            phase_reg          <= phase_next;
            first_class_reg    <= first_class_next;
            length_count_reg   <= length_count_next;
            negative_reg       <= negative_next;
            fault_reg          <= fault_next;
            integer_acc_reg    <= integer_acc_next;
            fraction_acc_reg   <= fraction_acc_next;
            fraction_count_reg <= fraction_count_next;
            error_reg          <= error_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= final_value;
                out_error_reg <= error_reg;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign text.ready   = (state_reg == S_PARSE);
    assign result.valid = out_valid_reg;
    assign result.value = out_value_reg;
    assign result.error = out_error_reg;

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
    else $error("fraction divider finished outside the divide state");

    // A terminator always starts the division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_term) |=> (state_reg == S_DIVIDE))
    else $error("terminator did not start the division");

    // Handing over a result leaves the parser at the start of a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && (phase_reg == PH_LEAD) &&
                      (integer_acc_reg == '0) && (fraction_count_reg == '0)))
    else $error("parser not cleared after a result");

    // No more fraction digits are kept than configured.
    assert property (@(posedge clk) disable iff (!rst_n)
        fraction_count_reg <= 4'(FRAC_DIGITS))
    else $error("fraction digit count over its limit");

endmodule

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top: self-checking bench for the decimal text to fixed point converter
// Streams zero-terminated strings into the text channel, predicts each
// Q32.32 result and error flag from its own parser, and checks every result
// transaction in order while both channels idle and stall at random.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import dtf_pkg::*;

    localparam int FRAC_DIGITS  = DTF_FRAC_DIGITS;
    localparam int FRAC_BITS    = DTF_FRAC_BITS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 320;

    typedef enum logic [2:0] {P_LEAD, P_SIGN, P_INT, P_FRAC, P_TRAIL} parse_phase_t;
    typedef enum logic [1:0] {LEAD_NONE, LEAD_DIGIT, LEAD_MINUS, LEAD_OTHER} lead_class_t;

    typedef struct {
        char_t ch;
        bit    drain;
    } text_byte_t;

    typedef struct {
        fixed_t value;
        logic   error;
    } conversion_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dtf_char_if   text_ch ();
    dtf_result_if result_ch ();

    decimal_text_to_fixed #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    always #5 clk = ~clk;

    // Stimulus backlog, expected conversions and run statistics.
    text_byte_t  text_backlog [$];
    char_t       text_buf [$];
    conversion_t expected_fixed [$];
    int unsigned bytes_accepted;
    int unsigned strings_sent;
    int unsigned results_seen;
    int unsigned error_results;
    int unsigned mismatches;
    int unsigned random_bytes;
    int unsigned random_strings;
    int unsigned cycle_count;

    // Parser state of the predictor.
    parse_phase_t parse_phase;
    lead_class_t  lead_class;
    logic [3:0]   text_len;
    logic         neg_sign;
    logic         format_fault;
    logic [31:0]  int_acc;
    logic [29:0]  frac_acc;
    logic [3:0]   frac_kept;

    // Sender burst and gap counters.
    int unsigned burst_left;
    int unsigned gap_left;

    // Receiver stall pattern.
    int unsigned ready_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned holds_done;

    // Return the predictor to the start of a string.
    task automatic clear_parser();
        parse_phase  = P_LEAD;
        lead_class   = LEAD_NONE;
        text_len     = 4'd0;
        neg_sign     = 1'b0;
        format_fault = 1'b0;
        int_acc      = 32'd0;
        frac_acc     = 30'd0;
        frac_kept    = 4'd0;
    endtask

    // Saturating decimal accumulation of one integer digit.
    task automatic accumulate_integer(input char_t c);
        logic [63:0] wide;
        wide = {32'd0, int_acc} * 64'd10 + 64'(c - CH_ZERO);
        int_acc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    endtask

    // Advance the parser by one accepted byte; a terminator yields a conversion.
    task automatic parse_text_byte(input char_t c);
        logic [63:0] scale;
        logic [63:0] frac_bits;
        logic [63:0] mag;
        bit          digit_char;
        bit          blank_char;
        bit          flag;
        int          n;
        conversion_t conv;
        digit_char = c inside {[CH_ZERO:CH_NINE]};
        blank_char = c inside {CH_SPACE, [CH_TAB:CH_CR]};
        if (c != CH_NUL)
        begin
            if (lead_class == LEAD_NONE)
            begin
                lead_class = digit_char ? LEAD_DIGIT
                                        : ((c == CH_MINUS) ? LEAD_MINUS : LEAD_OTHER);
            end
            if (text_len != 4'd15)
            begin
                text_len = text_len + 4'd1;
            end
            case (parse_phase)
                P_LEAD:
                begin
                    if (blank_char)
                    begin
                        parse_phase = P_LEAD;
                    end
                    else if (digit_char)
                    begin
                        accumulate_integer(c);
                        parse_phase = P_INT;
                    end
                    else if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        neg_sign    = (c == CH_MINUS);
                        parse_phase = P_SIGN;
                    end
                    else
                    begin
                        format_fault = 1'b1;
                        parse_phase  = (c == CH_DOT) ? P_FRAC : P_TRAIL;
                    end
                end
                P_SIGN:
                begin
                    if (digit_char)
                    begin
                        accumulate_integer(c);
                        parse_phase = P_INT;
                    end
                    else
                    begin
                        format_fault = 1'b1;
                        parse_phase  = (c == CH_DOT) ? P_FRAC : P_TRAIL;
                    end
                end
                P_INT:
                begin
                    if (digit_char)
                    begin
                        accumulate_integer(c);
                    end
                    else if (c == CH_DOT)
                    begin
                        parse_phase = P_FRAC;
                    end
                    else
                    begin
                        format_fault = 1'b1;
                        parse_phase  = P_TRAIL;
                    end
                end
                P_FRAC:
                begin
                    if (digit_char)
                    begin
                        // Digits past the kept count are swallowed silently.
                        if (frac_kept < FRAC_DIGITS && frac_kept < 9)
                        begin
                            frac_acc  = frac_acc * 30'd10 + 30'(c - CH_ZERO);
                            frac_kept = frac_kept + 4'd1;
                        end
                    end
                    else
                    begin
                        format_fault = 1'b1;
                        parse_phase  = P_TRAIL;
                    end
                end
                default:
                begin
                    format_fault = 1'b1;
                    parse_phase  = P_TRAIL;
                end
            endcase
        end
        else
        begin
            // Convert the kept decimal fraction to binary by truncating division.
            n = (frac_kept > 9) ? 9 : int'(frac_kept);
            scale = 64'd1;
            repeat (n) scale = scale * 64'd10;
            frac_bits = ({34'd0, frac_acc} << FRAC_BITS) / scale;
            mag = ({32'd0, int_acc} << FRAC_BITS) + frac_bits;

            flag = format_fault || parse_phase == P_LEAD || parse_phase == P_SIGN
                || lead_class == LEAD_NONE
                || (lead_class == LEAD_DIGIT && text_len > DTF_LEN_DIGIT_MAX)
                || (lead_class == LEAD_MINUS && text_len > DTF_LEN_MINUS_MAX)
                || int_acc > DTF_MAX_MAG
                || (int_acc == DTF_MAX_MAG && frac_acc != 30'd0);

            // Clamp the magnitude to what the signed result can hold.
            if (neg_sign)
            begin
                if (mag > 64'h8000_0000_0000_0000)
                begin
                    mag = 64'h8000_0000_0000_0000;
                end
                conv.value = fixed_t'(64'd0 - mag);
            end
            else
            begin
                if (mag > 64'h7FFF_FFFF_FFFF_FFFF)
                begin
                    mag = 64'h7FFF_FFFF_FFFF_FFFF;
                end
                conv.value = fixed_t'(mag);
            end
            conv.error = flag;
            expected_fixed.push_back(conv);
            clear_parser();
        end
    endtask

    // Move the scratch string plus a terminator into the backlog.
    task automatic commit_text(input bit drain);
        text_byte_t item;
        foreach (text_buf[i])
        begin
            item.ch    = text_buf[i];
            item.drain = drain && (i == 0);
            text_backlog.push_back(item);
        end
        item.ch    = CH_NUL;
        item.drain = drain && (text_buf.size() == 0);
        text_backlog.push_back(item);
        text_buf.delete();
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(char_t'(s[i]));
        end
    endtask

    task automatic queue_literal(input string s);
        append_text(s);
        commit_text(1'b0);
    endtask

    task automatic append_digits(input int count);
        repeat (count) text_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
    endtask

    // Number-shaped text: optional whitespace, sign, integer part and fraction.
    task automatic build_number();
        longint unsigned near_max;
        int unsigned     pick;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                pick = $urandom_range(0, 6);
                text_buf.push_back((pick > 4) ? CH_SPACE : CH_TAB + char_t'(pick));
            end
        end
        pick = $urandom_range(0, 2);
        if (pick == 1)
        begin
            text_buf.push_back(CH_PLUS);
        end
        else if (pick == 2)
        begin
            text_buf.push_back(CH_MINUS);
        end
        pick = $urandom_range(0, 9);
        if (pick == 1)
        begin
            // Values around the largest accepted magnitude.
            near_max = 64'd2147483640 + $urandom_range(0, 15);
            append_text($sformatf("%0d", near_max));
        end
        else if (pick == 2)
        begin
            append_digits($urandom_range(11, 13));
        end
        else if (pick != 0)
        begin
            append_digits(($urandom_range(0, 3) == 0) ? $urandom_range(7, 10)
                                                      : $urandom_range(1, 5));
        end
        if (pick == 0 || $urandom_range(0, 4) < 3)
        begin
            text_buf.push_back(CH_DOT);
            append_digits(($urandom_range(0, 3) == 0) ? $urandom_range(7, 12)
                                                      : $urandom_range(0, 4));
        end
    endtask

    // Text driver: bursts of bytes from the backlog with random gaps.
    always @(posedge clk or negedge rst_n)
    begin : text_driver
        text_byte_t item;
        logic       next_valid;
        char_t      next_char;
        bit         took_end;
        if (!rst_n)
        begin
            text_ch.valid     <= 1'b0;
            text_ch.character <= CH_NUL;
            bytes_accepted    <= 0;
            strings_sent      <= 0;
            burst_left        = $urandom_range(1, 24);
            gap_left          = 0;
            clear_parser();
        end
        else
        begin
            took_end   = 1'b0;
            next_valid = text_ch.valid;
            next_char  = text_ch.character;
            if (text_ch.valid && text_ch.ready)
            begin
                took_end = (text_ch.character == CH_NUL);
                parse_text_byte(text_ch.character);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (text_backlog.size() != 0
                         && !(text_backlog[0].drain
                              && strings_sent + took_end != results_seen))
                begin
                    item       = text_backlog.pop_front();
                    next_valid = 1'b1;
                    next_char  = item.ch;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            text_ch.valid     <= next_valid;
            text_ch.character <= next_char;
            if (text_ch.valid && text_ch.ready)
            begin
                bytes_accepted <= bytes_accepted + 1;
            end
            if (took_end)
            begin
                strings_sent <= strings_sent + 1;
            end
        end
    end

    // Result receiver: random stall modes plus two long hold-offs.
    always @(posedge clk or negedge rst_n)
    begin : result_receiver
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            ready_mode      = 0;
            mode_left       = 0;
            hold_left       = 0;
            holds_done      = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if ((holds_done == 0 && bytes_accepted >= 100)
                 || (holds_done == 1 && bytes_accepted >= 400))
        begin
            hold_left = HOLD_CYCLES;
            holds_done++;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(1, 64);
            end
            else
            begin
                mode_left--;
            end
            case (ready_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
                default: result_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Result monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        conversion_t want;
        if (!rst_n)
        begin
            results_seen  <= 0;
            error_results <= 0;
        end
        else if (result_ch.valid && result_ch.ready)
        begin
            if (expected_fixed.size() == 0)
            begin
                $display("%0t: unexpected result, value %0d error %0b", $realtime,
                         result_ch.value, result_ch.error);
                mismatches++;
            end
            else
            begin
                want = expected_fixed.pop_front();
                if (result_ch.value !== want.value)
                begin
                    $display("%0t: value mismatch, expected %0d (%h), actual %0d (%h)",
                             $realtime, want.value, want.value, result_ch.value,
                             result_ch.value);
                    mismatches++;
                end
                if (result_ch.error !== want.error)
                begin
                    $display("%0t: error flag mismatch, expected %0b, actual %0b",
                             $realtime, want.error, result_ch.error);
                    mismatches++;
                end
            end
            results_seen <= results_seen + 1;
            if (result_ch.error === 1'b1)
            begin
                error_results <= error_results + 1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stimulus
        int unsigned pick;
        int unsigned pos;
        text_ch.valid     = 1'b0;
        text_ch.character = CH_NUL;
        result_ch.ready   = 1'b0;
        mismatches        = 0;
        cycle_count       = 0;
        random_bytes      = 0;
        random_strings    = 0;

        // Directed strings: extremes and special cases of the grammar.
        commit_text(1'b0);
        for (int i = 0; i <= 4; i++)
        begin
            text_buf.push_back(CH_TAB + char_t'(i));
        end
        text_buf.push_back(CH_SPACE);
        commit_text(1'b0);
        queue_literal("0");
        queue_literal("2147483647");
        queue_literal("-2147483648");
        queue_literal("-2147483647.5");
        queue_literal("12345678901");
        queue_literal("99999999999999");
        queue_literal("+.5");
        queue_literal("-");
        queue_literal(".25");
        queue_literal("12a34");
        queue_literal("3.14159265358979");
        queue_literal("-0");
        queue_literal("2147483647.1");
        queue_literal(" +7.000000001");
        queue_literal("0.999999999");
        queue_literal("--5");
        queue_literal("1..2");
        queue_literal("  -12.5  ");
        queue_literal("+42");
        append_text("1.");
        text_buf.push_back(8'hFF);
        commit_text(1'b0);

        // Random strings: mostly well-formed, some broken, some pure noise.
        while (random_bytes < RANDOM_BYTES || random_strings < 30)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                build_number();
            end
            else if (pick < 85)
            begin
                build_number();
                if (text_buf.size() != 0 && $urandom_range(0, 1) == 0)
                begin
                    pos = $urandom_range(0, text_buf.size() - 1);
                    text_buf[pos] = char_t'($urandom_range(1, 255));
                end
                else
                begin
                    pos = $urandom_range(0, text_buf.size());
                    case ($urandom_range(0, 4))
                        0:       text_buf.insert(pos, CH_PLUS);
                        1:       text_buf.insert(pos, CH_MINUS);
                        2:       text_buf.insert(pos, CH_DOT);
                        3:       text_buf.insert(pos, CH_SPACE);
                        default: text_buf.insert(pos, char_t'($urandom_range(1, 255)));
                    endcase
                end
            end
            else
            begin
                repeat ($urandom_range(0, 12)) text_buf.push_back(char_t'($urandom_range(1, 255)));
            end
            random_bytes += text_buf.size() + 1;
            commit_text(random_strings == 0 || random_strings == 15);
            random_strings++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (text_backlog.size() != 0 || text_ch.valid || strings_sent != results_seen)
        begin
            @(negedge clk);
        end
        repeat (2 * FRAC_BITS) @(negedge clk);

        if (expected_fixed.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $realtime,
                     expected_fixed.size());
            mismatches++;
        end
        $display("Run fed %0d text bytes forming %0d strings; %0d results came back,",
                 bytes_accepted, strings_sent, results_seen);
        $display("%0d of them flagged as format or range errors.", error_results);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
